/* hw/rtl/hawrf_pkg.sv */
// Package with the request, response and control types of the handle allocator.
`timescale 1ns / 1ps
package hawrf_pkg;

  localparam int HANDLE_W    = 31;
  localparam int PAYLOAD_F_W = 64;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_GET     = 2'd2,
    CMD_SET     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_IN_USE = 2'd1,
    ST_NO_SPACE   = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [HANDLE_W-1:0]    handle;
    logic [PAYLOAD_F_W-1:0] payload_in;
  } in_req_t;

  typedef struct packed {
    status_t                status;
    logic [HANDLE_W-1:0]    handle_out;
    logic [PAYLOAD_F_W-1:0] payload_out;
  } out_rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic pop;
    logic push;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

/* hw/rtl/hawrf_recycle_fifo.sv */
// Recycle FIFO of released handle offsets, held in a synchronous memory.
`timescale 1ns / 1ps
module hawrf_recycle_fifo #(
  parameter int NUM_HANDLES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hawrf_pkg::fifo_ctrl_t          ctrl,
  input  logic [$clog2(NUM_HANDLES)-1:0] push_data,
  output logic [$clog2(NUM_HANDLES)-1:0] head_data,
  output hawrf_pkg::fifo_stat_t          stat
);
  import hawrf_pkg::*;

  localparam int IDX_W = $clog2(NUM_HANDLES);
  localparam int CNT_W = $clog2(NUM_HANDLES + 1);

  logic [IDX_W-1:0] mem [NUM_HANDLES];
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_data_r;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    wrap_inc = (p == IDX_W'(NUM_HANDLES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(NUM_HANDLES));
  assign head_data  = head_data_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctrl.pop && !stat.empty) begin
      head_nxt  = wrap_inc(head_r);
      count_nxt = count_r - 1'b1;
    end else if (ctrl.push && !stat.full) begin
      tail_nxt  = wrap_inc(tail_r);
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.pop && !stat.full) begin
      mem[tail_r] <= push_data;
    end
    head_data_r <= mem[head_r];
  end

endmodule

/* hw/rtl/handle_allocator_with_recycle_fifo_unit.sv */
// Top level of the handle allocator with recycle FIFO and per-handle payload store.
//
//   channel  ports                          direction  handshake
//   in       start, busy, in_req            input      start && !busy
//   out      out_strobe, out_rsp            output     one-cycle strobe
//   cfg      cfg_valid, cfg_ready, cfg_data input      cfg_valid && cfg_ready
//
// For each request the accept edge issues the memory reads and
// the following cycle reads, modifies, writes back and presents the response.
// A new request is not accepted until the previous response has been presented.
// After reset the in-use map is cleared entry by entry, during which busy is high.
// The receiver cannot stall; the configuration port is always ready.
`timescale 1ns / 1ps
module handle_allocator_with_recycle_fifo_unit #(
  parameter int NUM_HANDLES   = 256,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  hawrf_pkg::in_req_t           in_req,
  output logic                         out_strobe,
  output hawrf_pkg::out_rsp_t          out_rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hawrf_pkg::HANDLE_W-1:0] cfg_data
);
  import hawrf_pkg::*;

  localparam int IDX_W = $clog2(NUM_HANDLES);
  localparam int CNT_W = $clog2(NUM_HANDLES + 1);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]         clear_idx_r;
  logic [HANDLE_W-1:0]      base_r;
  logic [CNT_W-1:0]         next_fresh_r, next_fresh_nxt;
  cmd_t                     cmd_r;
  logic [HANDLE_W-1:0]      handle_r;
  logic [PAYLOAD_WIDTH-1:0] payload_r;
  logic [IDX_W-1:0]         off_r;
  logic                     inwin_r;

  logic                     in_use_mem [NUM_HANDLES];
  logic [PAYLOAD_WIDTH-1:0] payload_mem [NUM_HANDLES];
  logic                     in_use_rd_r;
  logic [PAYLOAD_WIDTH-1:0] payload_rd_r;

  logic                     accept;
  logic                     clearing;
  logic [HANDLE_W-1:0]      in_off;
  logic                     valid_h;
  logic [IDX_W-1:0]         slot;
  logic                     alloc_ok;
  logic                     use_we;
  logic [IDX_W-1:0]         use_addr;
  logic                     use_wdata;
  logic                     pay_we;
  logic [IDX_W-1:0]         pay_addr;
  fifo_ctrl_t               fctrl;
  fifo_stat_t               fstat;
  logic [IDX_W-1:0]         fifo_head_data;

  hawrf_recycle_fifo #(
    .NUM_HANDLES(NUM_HANDLES)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (fctrl),
    .push_data (off_r),
    .head_data (fifo_head_data),
    .stat      (fstat)
  );

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign in_off    = in_req.handle - base_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clear_idx_r == IDX_W'(NUM_HANDLES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    out_strobe = 1'b0;
    clearing   = 1'b0;
    case (state_r)
      S_CLEAR: clearing   = 1'b1;
      S_IDLE:  busy       = 1'b0;
      S_EXEC:  out_strobe = 1'b1;
      default: busy       = 1'b1;
    endcase
  end

  always_comb begin
    valid_h        = inwin_r && in_use_rd_r;
    alloc_ok       = !fstat.empty || (next_fresh_r != CNT_W'(NUM_HANDLES));
    slot           = !fstat.empty ? fifo_head_data : next_fresh_r[IDX_W-1:0];
    next_fresh_nxt = next_fresh_r;
    fctrl          = '0;
    use_we         = 1'b0;
    use_addr       = off_r;
    use_wdata      = 1'b0;
    pay_we         = 1'b0;
    pay_addr       = off_r;
    out_rsp.status      = ST_OK;
    out_rsp.handle_out  = handle_r;
    out_rsp.payload_out = '0;
    if (clearing) begin
      use_we   = 1'b1;
      use_addr = clear_idx_r;
    end else if (out_strobe) begin
      case (cmd_r)
        CMD_ALLOC: begin
          if (alloc_ok) begin
            fctrl.pop          = !fstat.empty;
            if (fstat.empty) begin
              next_fresh_nxt = next_fresh_r + 1'b1;
            end
            use_we             = 1'b1;
            use_addr           = slot;
            use_wdata          = 1'b1;
            pay_we             = 1'b1;
            pay_addr           = slot;
            out_rsp.handle_out = base_r + HANDLE_W'(slot);
          end else begin
            out_rsp.status = ST_NO_SPACE;
          end
        end
        CMD_RELEASE: begin
          if (!valid_h) begin
            out_rsp.status = ST_NOT_IN_USE;
          end else begin
            use_we = 1'b1;
            if (CNT_W'(off_r) + 1'b1 == next_fresh_r) begin
              next_fresh_nxt = next_fresh_r - 1'b1;
            end else begin
              fctrl.push = 1'b1;
            end
          end
        end
        CMD_GET: begin
          if (!valid_h) begin
            out_rsp.status = ST_NOT_IN_USE;
          end else begin
            out_rsp.payload_out = PAYLOAD_F_W'(payload_rd_r);
          end
        end
        CMD_SET: begin
          if (!valid_h) begin
            out_rsp.status = ST_NOT_IN_USE;
          end else begin
            pay_we = 1'b1;
          end
        end
        default: out_rsp.status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clear_idx_r  <= '0;
      base_r       <= '0;
      next_fresh_r <= '0;
    end else begin
      state_r      <= state_nxt;
      next_fresh_r <= next_fresh_nxt;
      if (clearing) begin
        clear_idx_r <= clear_idx_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_req.cmd;
      handle_r  <= in_req.handle;
      payload_r <= in_req.payload_in[PAYLOAD_WIDTH-1:0];
      off_r     <= in_off[IDX_W-1:0];
      inwin_r   <= (in_off < HANDLE_W'(NUM_HANDLES));
    end
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      in_use_mem[use_addr] <= use_wdata;
    end
    in_use_rd_r <= in_use_mem[in_off[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      payload_mem[pay_addr] <= payload_r;
    end
    payload_rd_r <= payload_mem[in_off[IDX_W-1:0]];
  end

endmodule

/* test/handle_alloc_checker.sv */
// Checker that predicts and compares every response of the handle allocator.
`timescale 1ns / 1ps
module handle_alloc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  hawrf_pkg::in_req_t             in_req,
  input  logic                           out_strobe,
  input  hawrf_pkg::out_rsp_t            out_rsp,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [hawrf_pkg::HANDLE_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending_rsp
);
  import hawrf_pkg::*;

  localparam int NUM_HANDLES = 256;

  logic [HANDLE_W-1:0]    window_base;
  int                     fresh_count;
  logic [7:0]             free_handle_q[$];
  logic                   handle_live[NUM_HANDLES];
  logic [PAYLOAD_F_W-1:0] payload_mem[NUM_HANDLES];
  out_rsp_t               expected_rsp_q[$];
  int                     error_tally = 0;

  function automatic out_rsp_t predict_handle_op(input in_req_t req);
    out_rsp_t            rsp;
    logic [HANDLE_W-1:0] off;
    logic                live;
    int                  slot;
    logic                got;
    rsp.status      = ST_OK;
    rsp.handle_out  = req.handle;
    rsp.payload_out = '0;
    off  = req.handle - window_base;
    live = (off < NUM_HANDLES) && handle_live[off[7:0]];
    case (req.cmd)
      CMD_ALLOC: begin
        got  = 1'b1;
        slot = 0;
        if (free_handle_q.size() > 0) begin
          slot = free_handle_q.pop_front();
        end else if (fresh_count < NUM_HANDLES) begin
          slot        = fresh_count;
          fresh_count = fresh_count + 1;
        end else begin
          got = 1'b0;
        end
        if (got) begin
          handle_live[slot] = 1'b1;
          payload_mem[slot] = req.payload_in;
          rsp.handle_out    = window_base + HANDLE_W'(slot);
        end else begin
          rsp.status = ST_NO_SPACE;
        end
      end
      CMD_RELEASE: begin
        if (!live) begin
          rsp.status = ST_NOT_IN_USE;
        end else begin
          handle_live[off[7:0]] = 1'b0;
          if (int'(off) + 1 == fresh_count) begin
            fresh_count = fresh_count - 1;
          end else if (free_handle_q.size() < NUM_HANDLES) begin
            free_handle_q.push_back(off[7:0]);
          end
        end
      end
      CMD_GET: begin
        if (!live) rsp.status = ST_NOT_IN_USE;
        else rsp.payload_out = payload_mem[off[7:0]];
      end
      default: begin
        if (!live) rsp.status = ST_NOT_IN_USE;
        else payload_mem[off[7:0]] = req.payload_in;
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_rsp_t exp_rsp;
    if (!rst_n) begin
      window_base = '0;
      fresh_count = 0;
      free_handle_q.delete();
      expected_rsp_q.delete();
      for (int i = 0; i < NUM_HANDLES; i++) begin
        handle_live[i] = 1'b0;
        payload_mem[i] = '0;
      end
    end else begin
      if (out_strobe) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response with no request outstanding: handle_out %0h", out_rsp.handle_out);
          error_tally++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (out_rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, out_rsp.status);
            error_tally++;
          end
          if (out_rsp.handle_out !== exp_rsp.handle_out) begin
            $error("handle_out: expected %0h, got %0h", exp_rsp.handle_out,
                   out_rsp.handle_out);
            error_tally++;
          end
          if (out_rsp.payload_out !== exp_rsp.payload_out) begin
            $error("payload_out: expected %0h, got %0h", exp_rsp.payload_out,
                   out_rsp.payload_out);
            error_tally++;
          end
        end
      end
      if (start && !busy) expected_rsp_q.push_back(predict_handle_op(in_req));
      if (cfg_valid && cfg_ready) window_base = cfg_data;
    end
    pending_rsp <= expected_rsp_q.size();
    fail_count  <= error_tally;
  end

  final begin
    if (expected_rsp_q.size() != 0)
      $error("%0d responses still outstanding", expected_rsp_q.size());
  end

endmodule

/* test/testbench.sv */
// Top of the handle allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import hawrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_req_t             in_req = '0;
  logic                out_strobe;
  out_rsp_t            out_rsp;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [HANDLE_W-1:0] cfg_data = '0;
  int                  fail_count;
  int                  pending_rsp;
  int                  stall_cycles = 0;
  logic [HANDLE_W-1:0] base_now = '0;

  always #1 clk = ~clk;

  handle_allocator_with_recycle_fifo_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  handle_alloc_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_strobe  (out_strobe),
    .out_rsp     (out_rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending_rsp (pending_rsp)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input cmd_t c, input logic [HANDLE_W-1:0] h,
                              input logic [PAYLOAD_F_W-1:0] p, input int idle_pct);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    start  <= 1'b1;
    in_req <= '{cmd: c, handle: h, payload_in: p};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rsp != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_base(input logic [HANDLE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    base_now   = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return HANDLE_W'($urandom);
    if (r < 75) return base_now + HANDLE_W'($urandom_range(0, 63));
    return base_now + HANDLE_W'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(input int n, input int idle_pct, input int alloc_w,
                           input int release_w, input int get_w);
    int   r;
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_w) c = CMD_ALLOC;
      else if (r < alloc_w + release_w) c = CMD_RELEASE;
      else if (r < alloc_w + release_w + get_w) c = CMD_GET;
      else c = CMD_SET;
      send_request(c, pick_handle(), {$urandom, $urandom}, idle_pct);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_base('0);

    // Directed requests: misses on an empty map, fresh and recycled handles,
    // stepping back the topmost fresh handle and handles outside the window.
    send_request(CMD_GET, 31'd0, '0, 0);
    send_request(CMD_RELEASE, 31'd0, '0, 0);
    send_request(CMD_ALLOC, 31'h7FFFFFFF, '1, 0);
    send_request(CMD_ALLOC, 31'd0, '0, 0);
    send_request(CMD_ALLOC, 31'd5, 64'hA5A5_5A5A_0F0F_F0F0, 0);
    send_request(CMD_GET, 31'd0, '0, 0);
    send_request(CMD_SET, 31'd1, '1, 0);
    send_request(CMD_GET, 31'd1, '0, 0);
    send_request(CMD_RELEASE, 31'd1, '0, 0);
    send_request(CMD_RELEASE, 31'd2, '0, 0);
    send_request(CMD_ALLOC, 31'd0, 64'h0123_4567_89AB_CDEF, 0);
    send_request(CMD_GET, 31'h7FFFFFFF, '1, 0);
    send_request(CMD_SET, 31'd256, '1, 0);
    send_request(CMD_RELEASE, 31'd0, '0, 0);
    send_request(CMD_RELEASE, 31'd1, '0, 0);
    send_request(CMD_GET, 31'd0, '0, 0);
    send_request(CMD_SET, 31'h7FFFFFFF, 64'hFFFF_0000_FFFF_0000, 0);
    send_request(CMD_ALLOC, 31'h2AAAAAAA, '0, 0);
    send_request(CMD_GET, 31'd0, '0, 0);
    drain_requests();

    // Mostly allocations, enough to run the fresh counter out.
    run_phase(300, 0, 95, 0, 5);
    drain_requests();

    // The window now wraps past the top of the handle space.
    write_base(31'h7FFFFF80);
    run_phase(300, 51, 25, 35, 20);
    drain_requests();

    write_base(31'h7FFFFFFF);
    run_phase(200, 14, 35, 25, 20);
    drain_requests();

    write_base(HANDLE_W'($urandom));
    run_phase(150, 51, 20, 50, 15);

    drain_requests();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* handle_allocator_with_recycle_fifo_unit.f */
hw/rtl/hawrf_pkg.sv
hw/rtl/hawrf_recycle_fifo.sv
hw/rtl/handle_allocator_with_recycle_fifo_unit.sv
test/handle_alloc_checker.sv
test/testbench.sv
